// File: rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Shared widths, result codes, controller states and the command and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package arpc_pkg;

   // Field widths of the request and response words.
   localparam int IP_W     = 32;
   localparam int MAC_W    = 48;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   // Default table depth.
   localparam int ENTRIES_DEFAULT = 16;

   // Request command codes.
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_LEARN  = 1'b1;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_HIT   = 3'd0,
      ST_MISS  = 3'd1,
      ST_NEW   = 3'd2,
      ST_KNOWN = 3'd3,
      ST_FULL  = 3'd4
   } status_type;

   // Controller states.
   typedef enum logic [0:0] {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;         // Capture the request word and restart the scan.
      logic       scan;         // Read the entry at the scan index and advance it.
      logic       learn_write;  // Append the captured pair at the fill index.
      logic       result;       // Load the response register.
      status_type code;         // Status to report with the result.
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic learn;      // The captured word is a learn.
      logic scan_end;   // Every filled entry has been read.
      logic match;      // The entry read last holds the captured IP.
      logic full;       // The table has no free entry.
      logic slot_free;  // The response register can take a new word.
   } dp_stat_type;

endpackage

// File: rtl/arpc_if.sv
// ----------------------------------------------------------------------------
// ARP cache channel interfaces
// Valid/ready channels for the request word and the response word.
// ----------------------------------------------------------------------------
interface arpc_req_if import arpc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             command;
   logic [IP_W-1:0]  ip_addr;
   logic [MAC_W-1:0] mac_in;

   modport source (output valid, output command, output ip_addr, output mac_in,
                   input ready);
   modport sink   (input valid, input command, input ip_addr, input mac_in,
                   output ready);
endinterface

interface arpc_rsp_if import arpc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [MAC_W-1:0]    mac_out;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output mac_out, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input mac_out, input entry_count,
                   output ready);
endinterface

// File: rtl/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// ARP cache controller
// Accepts a request word, steps the table scan and decides the outcome.
// ----------------------------------------------------------------------------
module arpc_ctrl import arpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.code  = ST_MISS;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.match) begin
               // The first matching entry ends the scan.
               if (stat.slot_free) begin
                  cmd.result = 1'b1;
                  cmd.code   = stat.learn ? ST_KNOWN : ST_HIT;
                  state_in   = S_IDLE;
               end
            end else if (!stat.scan_end) begin
               cmd.scan = 1'b1;
            end else if (stat.slot_free) begin
               // No entry matched: report a miss, or append the pair if room is left.
               cmd.result = 1'b1;
               state_in   = S_IDLE;
               if (!stat.learn) begin
                  cmd.code = ST_MISS;
               end else if (stat.full) begin
                  cmd.code = ST_FULL;
               end else begin
                  cmd.code        = ST_NEW;
                  cmd.learn_write = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/arpc_datapath.sv
// ----------------------------------------------------------------------------
// ARP cache datapath
// Holds the IP and MAC tables, the fill count, the scan index, the captured
// request word and the response register.
// ----------------------------------------------------------------------------
module arpc_datapath import arpc_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_command,
   input  logic [IP_W-1:0]     req_ip_addr,
   input  logic [MAC_W-1:0]    req_mac_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [MAC_W-1:0]    rsp_mac_out,
   output logic [COUNT_W-1:0]  rsp_entry_count,
   input  ctrl_cmd_type        cmd,
   output dp_stat_type         stat
);

   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

   // Tables.
   logic [IP_W-1:0]  ip_mem  [ENTRIES];
   logic [MAC_W-1:0] mac_mem [ENTRIES];

   // Captured request word.
   logic             cmd_ff;
   logic [IP_W-1:0]  ip_ff;
   logic [MAC_W-1:0] mac_ff;

   // Scan state and registered table read.
   logic [CNT_W-1:0] fill_ff,  fill_in;
   logic [CNT_W-1:0] scan_ff,  scan_in;
   logic             pend_ff,  pend_in;
   logic [IP_W-1:0]  rd_ip_ff;
   logic [MAC_W-1:0] rd_mac_ff;

   // Response register.
   logic                out_valid_ff, out_valid_in;
   status_type          status_ff;
   logic [MAC_W-1:0]    mac_out_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]    fill_next;

   // Table write on append, registered read at the scan index.
   always_ff @(posedge clock) begin
      if (cmd.learn_write) begin
         ip_mem[fill_ff[IDX_W-1:0]]  <= ip_ff;
         mac_mem[fill_ff[IDX_W-1:0]] <= mac_ff;
      end
      if (cmd.scan) begin
         rd_ip_ff  <= ip_mem[scan_ff[IDX_W-1:0]];
         rd_mac_ff <= mac_mem[scan_ff[IDX_W-1:0]];
      end
   end

   // Next values of the control registers.
   always_comb begin
      fill_in = fill_next;
      scan_in = scan_ff;
      pend_in = pend_ff;
      if (cmd.load) begin
         scan_in = '0;
         pend_in = 1'b0;
      end else if (cmd.scan) begin
         scan_in = scan_ff + 1'b1;
         pend_in = 1'b1;
      end
      out_valid_in = out_valid_ff;
      if (cmd.result) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign fill_next = cmd.learn_write ? fill_ff + 1'b1 : fill_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Request capture and response payload.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_command;
         ip_ff  <= req_ip_addr;
         mac_ff <= req_mac_in;
      end
      if (cmd.result) begin
         status_ff  <= cmd.code;
         mac_out_ff <= (cmd.code == ST_HIT) ? rd_mac_ff : '0;
         count_ff   <= COUNT_W'(fill_next);
      end
   end

   // Status toward the controller.
   always_comb begin
      stat.learn     = (cmd_ff == CMD_LEARN);
      stat.scan_end  = (scan_ff == fill_ff);
      stat.match     = pend_ff && (rd_ip_ff == ip_ff);
      stat.full      = (fill_ff == FULL_COUNT);
      stat.slot_free = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_mac_out     = mac_out_ff;
   assign rsp_entry_count = count_ff;

endmodule

// File: rtl/arp_cache_lookup_learn.sv
// A word is accepted only while no other word is in flight: the scan reads
// the filled entries in order and stops at the first match, then the response
// is loaded once the response register is free. The scan reads one table entry
// per cycle through one memory port.
// Reset clears the fill count and the response valid flag; table contents are
// left as they are and never read before they are written.
// ----------------------------------------------------------------------------
// ARP cache lookup and learn
// Maps IPv4 addresses to MAC addresses: lookups search the filled entries in
// order, learns append new pairs and keep the MAC of a known address.
// ----------------------------------------------------------------------------
module arp_cache_lookup_learn import arpc_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   arpc_req_if.sink   req_ch,
   arpc_rsp_if.source rsp_ch
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // Sequencer for one word at a time.
   arpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Tables, scan and response register.
   arpc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_ch.command),
      .req_ip_addr     (req_ch.ip_addr),
      .req_mac_in      (req_ch.mac_in),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_mac_out     (rsp_ch.mac_out),
      .rsp_entry_count (rsp_ch.entry_count),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// ARP cache lookup and learn testbench
// Drives lookup and learn words into the cache, tracks the expected answer of
// each accepted word with a table of its own, and compares every response word
// field by field in order. Directed tests cover the empty table, extreme
// addresses, duplicate learns and a full table; random traffic follows with
// varying gaps on the request side and stalls on the response side.
// ----------------------------------------------------------------------------
module tb_top import arpc_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH    = ENTRIES_DEFAULT;
   localparam int MAX_IDLE       = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;

   // One expected response word.
   typedef struct {
      status_type        status;
      logic [MAC_W-1:0]  mac;
      logic [COUNT_W-1:0] count;
   } arp_answer_type;

   logic clock;
   logic reset;

   arpc_req_if req_ch ();
   arpc_rsp_if rsp_ch ();

   arp_cache_lookup_learn #(
      .ENTRIES(TABLE_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // Shadow copy of the cache contents.
   logic [IP_W-1:0]  shadow_ip  [TABLE_DEPTH];
   logic [MAC_W-1:0] shadow_mac [TABLE_DEPTH];
   int               shadow_fill;

   arp_answer_type   pending_answers [$];
   logic [IP_W-1:0]  learned_ips [$];
   int               mismatch_count;
   int               quiet_cycles;
   bit               req_gaps_on;
   bit               rsp_stalls_on;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Draws a random MAC address.
   function automatic logic [MAC_W-1:0] rand_mac();
      return MAC_W'({$urandom(), $urandom()});
   endfunction

   // Works out the answer to one word and updates the shadow table.
   function automatic arp_answer_type resolve_arp(logic cmd, logic [IP_W-1:0] ip,
                                                  logic [MAC_W-1:0] mac);
      arp_answer_type ans;
      int             hit_idx;
      hit_idx = -1;
      for (int i = 0; i < shadow_fill; i++) begin
         if (hit_idx < 0 && shadow_ip[i] == ip) hit_idx = i;
      end
      ans.mac = '0;
      if (cmd == CMD_LOOKUP) begin
         if (hit_idx >= 0) begin
            ans.status = ST_HIT;
            ans.mac    = shadow_mac[hit_idx];
         end else begin
            ans.status = ST_MISS;
         end
      end else if (hit_idx >= 0) begin
         ans.status = ST_KNOWN;
      end else if (shadow_fill < TABLE_DEPTH) begin
         shadow_ip[shadow_fill]  = ip;
         shadow_mac[shadow_fill] = mac;
         shadow_fill++;
         ans.status = ST_NEW;
      end else begin
         ans.status = ST_FULL;
      end
      ans.count = COUNT_W'(shadow_fill);
      return ans;
   endfunction

   // Checks each response word against the oldest expectation, then records
   // the answer of a request word taken at the same edge.
   always @(posedge clock) begin
      arp_answer_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_answers.size() == 0) begin
               $error("response word with no word outstanding");
               mismatch_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                  mismatch_count++;
               end
               if (rsp_ch.mac_out !== want.mac) begin
                  $error("mac_out: expected %h, got %h", want.mac, rsp_ch.mac_out);
                  mismatch_count++;
               end
               if (rsp_ch.entry_count !== want.count) begin
                  $error("entry_count: expected %0d, got %0d", want.count,
                         rsp_ch.entry_count);
                  mismatch_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            pending_answers.push_back(resolve_arp(req_ch.command, req_ch.ip_addr,
                                                  req_ch.mac_in));
         end
      end
   end

   // Watchdog: ends the run when no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response side: stalls a random number of cycles after each word taken.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = rsp_stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // Sends one request word after a random gap and waits until it is taken.
   task automatic send_word(logic cmd, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.ip_addr <= ip;
      req_ch.mac_in  <= mac;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Lookups into the empty table must miss, whatever the address.
   task automatic test_empty_table();
      send_word(CMD_LOOKUP, '0, '1);
      send_word(CMD_LOOKUP, '1, '0);
   endtask

   // Extreme addresses, hits on both, a duplicate learn that keeps the MAC
   // already stored, and a lookup of address 1 that misses.
   task automatic test_learn_extremes();
      send_word(CMD_LEARN, '0, '0);
      send_word(CMD_LEARN, '1, '1);
      learned_ips.push_back('0);
      learned_ips.push_back('1);
      send_word(CMD_LOOKUP, '0, '1);
      send_word(CMD_LOOKUP, '1, '0);
      send_word(CMD_LEARN, '1, '0);
      send_word(CMD_LOOKUP, '1, rand_mac());
      send_word(CMD_LOOKUP, IP_W'(1), '0);
   endtask

   // Fills the remaining entries, then learns into the full table and looks
   // up the last entry, which takes the longest scan to match.
   task automatic test_fill_to_full();
      logic [IP_W-1:0] ip;
      for (int k = 1; k <= TABLE_DEPTH - 2; k++) begin
         ip = {24'($urandom() >> 8), 8'(k)};
         learned_ips.push_back(ip);
         send_word(CMD_LEARN, ip, rand_mac());
      end
      send_word(CMD_LEARN, {24'h00_0000, 8'h80}, rand_mac());
      send_word(CMD_LOOKUP, ip, '0);
   endtask

   // Random mix of hits, misses, near misses, known and dropped learns.
   task automatic test_random_traffic(int count, bit gaps, bit stalls);
      logic [IP_W-1:0] ip;
      int              pick;
      req_gaps_on   = gaps;
      rsp_stalls_on = stalls;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         ip   = learned_ips[$urandom_range(0, learned_ips.size() - 1)];
         if (pick < 40) begin
            send_word(CMD_LOOKUP, ip, rand_mac());
         end else if (pick < 55) begin
            // One flipped bit must not match.
            ip[$urandom_range(0, IP_W - 1)] ^= 1'b1;
            send_word(CMD_LOOKUP, ip, rand_mac());
         end else if (pick < 70) begin
            send_word(CMD_LOOKUP, $urandom(), rand_mac());
         end else if (pick < 85) begin
            send_word(CMD_LEARN, ip, rand_mac());
         end else begin
            send_word(CMD_LEARN, $urandom(), rand_mac());
         end
      end
   endtask

   // Test sequence.
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.command = CMD_LOOKUP;
      req_ch.ip_addr = '0;
      req_ch.mac_in  = '0;
      req_gaps_on    = 1'b1;
      rsp_stalls_on  = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_learn_extremes();
      test_fill_to_full();
      test_random_traffic(400, 1'b1, 1'b1);
      test_random_traffic(400, 1'b0, 1'b0);
      test_random_traffic(400, 1'b1, 1'b0);
      test_random_traffic(400, 1'b0, 1'b1);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/arpc_pkg.sv
rtl/arpc_if.sv
rtl/arpc_ctrl.sv
rtl/arpc_datapath.sv
rtl/arp_cache_lookup_learn.sv
tb/sv/tb_top.sv
